/* sv/moexy_pkg.sv */
// Shared types, constants and helper functions of the median / 1-Euro x-y filter.
// No dependencies; every other file of the block but moexy_checker imports this package.
package moexy_pkg;

    // Default length of the running median window.
    localparam int WINDOW_TAPS_DEF = 3;

    // 1e10 / (2 pi), rounded: the time constant scale for cutoffs in mHz and dt in 0.1 us.
    localparam logic [63:0] TAU_K = 64'd1591549431;
    // Saturation level of the dt * fc product.
    localparam logic [63:0] P_SAT = 64'h4000_0000_0000_0000;
    // Alpha of one in Q16.
    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    // Scale from us to 0.1 us over one second: speed is in units per second.
    localparam logic [63:0] SPEED_SCALE = 64'd10000000;
    // Gain term scale from Hz to mHz.
    localparam logic [63:0] MHZ_SCALE = 64'd1000;

    // Configuration register indexes.
    localparam logic [1:0] REG_NOMINAL   = 2'd0;
    localparam logic [1:0] REG_MIN_CUT   = 2'd1;
    localparam logic [1:0] REG_GAIN      = 2'd2;
    localparam logic [1:0] REG_SPEED_CUT = 2'd3;

    // Operations of the shared arithmetic unit.
    typedef enum logic
    {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed
    {
        logic        start;
        alu_op_t     op;
        logic [79:0] opa;
        logic [63:0] opb;
    } alu_req_t;

    // Response of the arithmetic unit.
    typedef struct packed
    {
        logic        done;
        logic [79:0] res;
    } alu_rsp_t;

    // Denominator of the alpha divide: min(dt * fc, 2^62) + K.
    function automatic logic [63:0] alpha_den(input logic [79:0] prod);
        logic        over;
        logic [63:0] p;
        begin
            over = (|prod[79:63]) || (prod[62] && (|prod[61:0]));
            p    = over ? P_SAT : {1'b0, prod[62:0]};
            return p + TAU_K;
        end
    endfunction

    // Rounded numerator of the alpha divide: K * 2^16 + den / 2.
    function automatic logic [63:0] alpha_num(input logic [63:0] den);
        begin
            return (TAU_K << 16) + (den >> 1);
        end
    endfunction

endpackage

/* sv/moexy_alu.sv */
// Shared bit-serial multiply and restoring divide unit of the x-y filter.
// Depends on moexy_pkg for the request and response types.
module moexy_alu
    import moexy_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    alu_op_t     op_reg, op_next;
    logic [79:0] acc_reg, acc_next;
    logic [79:0] opd_reg, opd_next;
    logic [63:0] opb_reg, opb_next;

    // One multiplier bit or one quotient bit per cycle.
    always_comb
    begin
        logic [64:0] rem_s;
        logic [64:0] rem_d;
        logic        ge;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        opd_next  = opd_reg;
        opb_next  = opb_reg;
        rem_s     = {acc_reg[63:0], opd_reg[63]};
        ge        = (rem_s >= {1'b0, opb_reg});
        rem_d     = ge ? (rem_s - {1'b0, opb_reg}) : rem_s;
        if (busy_reg)
        begin
            unique case (op_reg)
                ALU_MUL:
                begin
                    if (opb_reg[0])
                    begin
                        acc_next = acc_reg + opd_reg;
                    end
                    opd_next = opd_reg << 1;
                    opb_next = opb_reg >> 1;
                end
                ALU_DIV:
                begin
                    acc_next = {16'b0, rem_d[63:0]};
                    opd_next = {16'b0, opd_reg[62:0], ge};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            acc_next  = '0;
            opb_next  = req.opb;
            if (req.op == ALU_MUL)
            begin
                opd_next = req.opa;
                cnt_next = 6'd31;
            end
            else
            begin
                opd_next = {16'b0, req.opa[63:0]};
                cnt_next = 6'd63;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    // Operand and result registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opd_reg <= opd_next;
        opb_reg <= opb_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = (op_reg == ALU_DIV) ? {16'b0, opd_reg[63:0]} : acc_reg;

endmodule

/* sv/moexy_median.sv */
// Sample history and running median of both axes of the x-y filter.
// Depends on moexy_pkg for the default window length.
module moexy_median
    import moexy_pkg::*;
#(
    parameter int TAPS = WINDOW_TAPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    output logic signed [31:0] x_med,
    output logic signed [31:0] y_med
);

    localparam int FW = $clog2(TAPS + 1);
    localparam int SW = (TAPS > 1) ? $clog2(TAPS) : 1;

    logic signed [31:0] xh_reg [TAPS];
    logic signed [31:0] yh_reg [TAPS];
    logic [SW-1:0]      slot_reg;
    logic [FW-1:0]      fill_reg;

    // History entries are written in ring order.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            xh_reg[slot_reg] <= x_in;
            yh_reg[slot_reg] <= y_in;
        end
    end

    // Ring pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else if (wr_en)
        begin
            slot_reg <= (slot_reg == SW'(TAPS - 1)) ? '0 : slot_reg + 1'b1;
            if (fill_reg != FW'(TAPS))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // The median is the held sample whose stable rank equals half the fill count.
    always_comb
    begin
        logic [FW-1:0] rx;
        logic [FW-1:0] ry;
        x_med = '0;
        y_med = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            rx = '0;
            ry = '0;
            for (int j = 0; j < TAPS; j++)
            begin
                if ((FW'(j) < fill_reg) &&
                    ((xh_reg[j] < xh_reg[i]) || ((xh_reg[j] == xh_reg[i]) && (j < i))))
                begin
                    rx = rx + 1'b1;
                end
                if ((FW'(j) < fill_reg) &&
                    ((yh_reg[j] < yh_reg[i]) || ((yh_reg[j] == yh_reg[i]) && (j < i))))
                begin
                    ry = ry + 1'b1;
                end
            end
            if ((FW'(i) < fill_reg) && (rx == (fill_reg >> 1)))
            begin
                x_med = xh_reg[i];
            end
            if ((FW'(i) < fill_reg) && (ry == (fill_reg >> 1)))
            begin
                y_med = yh_reg[i];
            end
        end
    end

endmodule

/* sv/median_one_euro_xy_filter.sv */
// Top level of the median-prefiltered 1-Euro x-y position filter.
// Depends on moexy_pkg, moexy_median and moexy_alu.
//
//   Channel   Direction  Handshake              Content
//   s_*       in         s_tvalid / s_tready    x_pos, y_pos, interval_us
//   m_*       out        m_tvalid / m_tready    x_filt, y_filt
//   APB       in         psel/penable/pready    four filter registers
//
// Each word is worked through step by step by the shared bit-serial unit, with more
// steps once both axes are primed; a new word is taken only after the last is done.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so a new word is taken while m_tvalid is still held.
// Reset clears the registers to their defaults and empties the median window.
module median_one_euro_xy_filter
    import moexy_pkg::*;
#(
    parameter int WINDOW_TAPS = WINDOW_TAPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // x_pos[31:0], y_pos[63:32], interval_us[87:64]
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // x_filt[31:0], y_filt[63:32]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [5:0]
    {
        ST_IDLE  = 6'b000001,
        ST_MED   = 6'b000010,
        ST_ISSUE = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_AXIS  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef enum logic [9:0]
    {
        PH_SA_MUL   = 10'b0000000001,
        PH_SA_DIV   = 10'b0000000010,
        PH_VEL_MUL  = 10'b0000000100,
        PH_VEL_DIV  = 10'b0000001000,
        PH_SPD_MUL  = 10'b0000010000,
        PH_GAIN_MUL = 10'b0000100000,
        PH_K_MUL    = 10'b0001000000,
        PH_POS_MUL  = 10'b0010000000,
        PH_POS_DIV  = 10'b0100000000,
        PH_SM_MUL   = 10'b1000000000
    } phase_t;

    // Configuration registers.
    logic [19:0] nom_reg;
    logic [19:0] minc_reg;
    logic [23:0] gain_reg;
    logic [19:0] spdc_reg;

    // Sequencer and filter state.
    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic               ax_reg, ax_next;
    logic [1:0]         primed_reg, primed_next;
    logic signed [31:0] sm_reg [2];
    logic signed [31:0] sm_next [2];
    logic signed [39:0] spd_reg [2];
    logic signed [39:0] spd_next [2];
    logic               m_tvalid_reg, m_tvalid_next;
    logic [63:0]        out_reg, out_next;

    // Working registers.
    logic [29:0]        dt_reg, dt_next;
    logic signed [31:0] med_reg [2];
    logic signed [31:0] med_next [2];
    logic signed [32:0] diff_reg, diff_next;
    logic signed [39:0] raw_reg, raw_next;
    logic [63:0]        tmp_reg, tmp_next;
    logic [16:0]        asp_reg, asp_next;
    logic [16:0]        apos_reg, apos_next;

    logic               accept;
    logic signed [31:0] x_med;
    logic signed [31:0] y_med;
    alu_req_t           req;
    alu_rsp_t           rsp;

    logic [19:0]        nom_eff;
    logic [29:0]        dt_raw;
    logic [29:0]        dt_hi;
    logic [32:0]        absdiff;
    logic [39:0]        spdmag;
    logic signed [40:0] dspd;
    logic signed [63:0] lp;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign pready   = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nom_reg  <= 20'd1000;
            minc_reg <= 20'd1000;
            gain_reg <= 24'd0;
            spdc_reg <= 20'd1000;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_NOMINAL:   nom_reg  <= pwdata[19:0];
                REG_MIN_CUT:   minc_reg <= pwdata[19:0];
                REG_GAIN:      gain_reg <= pwdata[23:0];
                REG_SPEED_CUT: spdc_reg <= pwdata[19:0];
                default:       nom_reg  <= nom_reg;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_NOMINAL:   prdata = {12'b0, nom_reg};
            REG_MIN_CUT:   prdata = {12'b0, minc_reg};
            REG_GAIN:      prdata = {8'b0, gain_reg};
            REG_SPEED_CUT: prdata = {12'b0, spdc_reg};
            default:       prdata = '0;
        endcase
    end

    // Sample interval in 0.1 us, clamped to 0.1 .. 50 times nominal.
    always_comb
    begin
        nom_eff = (nom_reg == '0) ? 20'd1 : nom_reg;
        dt_raw  = ({6'b0, s_tdata[87:64]} << 3) + ({6'b0, s_tdata[87:64]} << 1);
        if (s_tdata[87:64] == '0)
        begin
            dt_raw = ({10'b0, nom_eff} << 3) + ({10'b0, nom_eff} << 1);
        end
        dt_hi = ({10'b0, nom_eff} << 9) - ({10'b0, nom_eff} << 3) - ({10'b0, nom_eff} << 2);
    end

    moexy_median #(.TAPS(WINDOW_TAPS)) u_median
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (accept),
        .x_in  (s_tdata[31:0]),
        .y_in  (s_tdata[63:32]),
        .x_med (x_med),
        .y_med (y_med)
    );

    moexy_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Values derived from the working registers.
    always_comb
    begin
        absdiff = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
        spdmag  = spd_reg[ax_reg][39] ? 40'(-spd_reg[ax_reg]) : 40'(spd_reg[ax_reg]);
        dspd    = {raw_reg[39], raw_reg} - {spd_reg[ax_reg][39], spd_reg[ax_reg]};
        lp      = $signed(rsp.res[63:0] + 64'd32768) >>> 16;
    end

    // Operands for each step of the sequence.
    always_comb
    begin
        req.start = (state_reg == ST_ISSUE);
        req.op    = ALU_MUL;
        req.opa   = '0;
        req.opb   = '0;
        unique case (phase_reg)
            PH_SA_MUL:
            begin
                req.opa = {60'b0, spdc_reg};
                req.opb = {34'b0, dt_reg};
            end
            PH_SA_DIV, PH_POS_DIV:
            begin
                req.op  = ALU_DIV;
                req.opa = {16'b0, alpha_num(tmp_reg)};
                req.opb = tmp_reg;
            end
            PH_VEL_MUL:
            begin
                req.opa = {47'b0, absdiff};
                req.opb = SPEED_SCALE;
            end
            PH_VEL_DIV:
            begin
                req.op  = ALU_DIV;
                req.opa = {16'b0, tmp_reg};
                req.opb = {34'b0, dt_reg};
            end
            PH_SPD_MUL:
            begin
                req.opa = {{39{dspd[40]}}, dspd};
                req.opb = {47'b0, asp_reg};
            end
            PH_GAIN_MUL:
            begin
                req.opa = {40'b0, spdmag};
                req.opb = {40'b0, gain_reg};
            end
            PH_K_MUL:
            begin
                req.opa = {16'b0, tmp_reg};
                req.opb = MHZ_SCALE;
            end
            PH_POS_MUL:
            begin
                req.opa = {16'b0, tmp_reg};
                req.opb = {34'b0, dt_reg};
            end
            PH_SM_MUL:
            begin
                req.opa = {{47{diff_reg[32]}}, diff_reg};
                req.opb = {47'b0, apos_reg};
            end
            default:
            begin
                req.opa = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        ax_next       = ax_reg;
        primed_next   = primed_reg;
        sm_next       = sm_reg;
        spd_next      = spd_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;
        dt_next       = dt_reg;
        med_next      = med_reg;
        diff_next     = diff_reg;
        raw_next      = raw_reg;
        tmp_next      = tmp_reg;
        asp_next      = asp_reg;
        apos_next     = apos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dt_next = dt_raw;
                    if (dt_raw < {10'b0, nom_eff})
                    begin
                        dt_next = {10'b0, nom_eff};
                    end
                    if (dt_raw > dt_hi)
                    begin
                        dt_next = dt_hi;
                    end
                    state_next = ST_MED;
                end
            end
            ST_MED:
            begin
                med_next[0] = x_med;
                med_next[1] = y_med;
                phase_next  = PH_SA_MUL;
                state_next  = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = ST_ISSUE;
                    unique case (phase_reg)
                        PH_SA_MUL:
                        begin
                            tmp_next   = alpha_den(rsp.res);
                            phase_next = PH_SA_DIV;
                        end
                        PH_SA_DIV:
                        begin
                            asp_next   = ALPHA_ONE - rsp.res[16:0];
                            ax_next    = 1'b0;
                            state_next = ST_AXIS;
                        end
                        PH_VEL_MUL:
                        begin
                            tmp_next   = rsp.res[63:0];
                            phase_next = PH_VEL_DIV;
                        end
                        PH_VEL_DIV:
                        begin
                            // Saturate the raw speed to 40 bits signed.
                            if (diff_reg[32])
                            begin
                                raw_next = (|rsp.res[63:39]) ? {1'b1, 39'b0}
                                                             : 40'(-rsp.res[39:0]);
                            end
                            else
                            begin
                                raw_next = (|rsp.res[63:39]) ? {1'b0, {39{1'b1}}}
                                                             : rsp.res[39:0];
                            end
                            phase_next = PH_SPD_MUL;
                        end
                        PH_SPD_MUL:
                        begin
                            spd_next[ax_reg] = spd_reg[ax_reg] + lp[39:0];
                            phase_next       = PH_GAIN_MUL;
                        end
                        PH_GAIN_MUL:
                        begin
                            tmp_next   = {16'b0, rsp.res[63:16]};
                            phase_next = PH_K_MUL;
                        end
                        PH_K_MUL:
                        begin
                            tmp_next   = {16'b0, rsp.res[63:16]} + {44'b0, minc_reg};
                            phase_next = PH_POS_MUL;
                        end
                        PH_POS_MUL:
                        begin
                            tmp_next   = alpha_den(rsp.res);
                            phase_next = PH_POS_DIV;
                        end
                        PH_POS_DIV:
                        begin
                            apos_next  = ALPHA_ONE - rsp.res[16:0];
                            phase_next = PH_SM_MUL;
                        end
                        PH_SM_MUL:
                        begin
                            sm_next[ax_reg] = sm_reg[ax_reg] + lp[31:0];
                            ax_next         = 1'b1;
                            state_next      = ax_reg ? ST_OUT : ST_AXIS;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_AXIS:
            begin
                if (!primed_reg[ax_reg])
                begin
                    // First sample of the axis passes through and primes it.
                    primed_next[ax_reg] = 1'b1;
                    sm_next[ax_reg]     = med_reg[ax_reg];
                    spd_next[ax_reg]    = '0;
                    ax_next             = 1'b1;
                    state_next          = ax_reg ? ST_OUT : ST_AXIS;
                end
                else
                begin
                    diff_next  = {med_reg[ax_reg][31], med_reg[ax_reg]}
                               - {sm_reg[ax_reg][31], sm_reg[ax_reg]};
                    phase_next = PH_VEL_MUL;
                    state_next = ST_ISSUE;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next      = {sm_reg[1], sm_reg[0]};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_SA_MUL;
            ax_reg       <= 1'b0;
            primed_reg   <= '0;
            sm_reg[0]    <= '0;
            sm_reg[1]    <= '0;
            spd_reg[0]   <= '0;
            spd_reg[1]   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            ax_reg       <= ax_next;
            primed_reg   <= primed_next;
            sm_reg       <= sm_next;
            spd_reg      <= spd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        dt_reg   <= dt_next;
        med_reg  <= med_next;
        diff_reg <= diff_next;
        raw_reg  <= raw_next;
        tmp_reg  <= tmp_next;
        asp_reg  <= asp_next;
        apos_reg <= apos_next;
    end

endmodule

/* sv/moexy_checker.sv */
// Port-level checks of the median / 1-Euro x-y filter, bound to its top level.
// Depends on median_one_euro_xy_filter for the bind target.
module moexy_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        pready
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // After a word is taken the block is busy working on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again without processing");

    // A new result appears only at the end of a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result word without work");

    // The register port never waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port stalled");

endmodule

bind median_one_euro_xy_filter moexy_checker u_moexy_checker (.*);

/* bench/testbench.sv */
// Self-checking bench for the median-prefiltered 1-Euro x-y position filter.
// Depends on moexy_pkg and median_one_euro_xy_filter; words are predicted in-bench.
`timescale 1ns / 100ps

module testbench;
    import moexy_pkg::*;

    localparam int   WATCHDOG_LIMIT = 40000;
    localparam int   LONG_HOLD      = 4000;
    localparam int   PHASE_WORDS    = 188;
    localparam int   N_DIRECTED     = 12;
    localparam int   N_PHASES       = 9;

    // Directed stimulus row; a set flag means the expected word is typed in.
    typedef struct
    {
        logic [31:0] x;
        logic [31:0] y;
        logic [23:0] iv;
        bit          fixed;
        logic [63:0] want;
    } dir_row_t;

    // One set of filter registers.
    typedef struct
    {
        logic [31:0] nominal;
        logic [31:0] min_cut;
        logic [31:0] gain;
        logic [31:0] speed_cut;
    } reg_set_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // x_pos[31:0], y_pos[63:32], interval_us[87:64]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // x_filt[31:0], y_filt[63:32]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Filter registers and state as the predictor sees them.
    logic [19:0] nominal_us;
    logic [19:0] min_cut_mhz;
    logic [23:0] gain_q16;
    logic [19:0] speed_cut_mhz;
    logic [31:0] hist_x [3];
    logic [31:0] hist_y [3];
    int          slot;
    int          fill;
    bit          primed [2];
    longint      smooth [2];
    longint      speed  [2];

    logic [63:0] filtered_words [$];
    logic [64:0] typed_words    [$];
    int          mismatches;
    int          idle_cycles;
    bit          hold_request;
    bit          quiet;
    int          hold_left;
    int          stall_left;

    dir_row_t    directed [N_DIRECTED];
    reg_set_t    phases   [N_PHASES];

    median_one_euro_xy_filter u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock with a 20 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Smoothing factor in Q16 for a time step dt (0.1 us) and a cutoff fc (mHz).
    function automatic longint smoothing_factor(logic [63:0] dt, logic [63:0] fc);
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] q;
        begin
            if (fc != 0 && fc > P_SAT / dt)
                p = P_SAT;
            else
                p = dt * fc;
            den = p + TAU_K;
            q = ((TAU_K << 16) + den / 2) / den;
            return longint'(65536) - longint'(q);
        end
    endfunction

    // One first-order low-pass step with Q16 alpha, rounded to nearest.
    function automatic longint low_pass(longint in_v, longint prev, longint a);
        begin
            return prev + (((in_v - prev) * a + 32768) >>> 16);
        end
    endfunction

    // Median of the samples held in the window.
    function automatic logic [31:0] window_median(logic [31:0] h [3], int n);
        logic signed [31:0] v [3];
        logic signed [31:0] t;
        begin
            for (int i = 0; i < 3; i++)
                v[i] = h[i];
            for (int i = 0; i < n; i++)
                for (int j = 0; j + 1 < n - i; j++)
                    if (v[j] > v[j + 1])
                    begin
                        t = v[j];
                        v[j] = v[j + 1];
                        v[j + 1] = t;
                    end
            return v[n / 2];
        end
    endfunction

    // 1-Euro stage of one axis; updates that axis' smoothed position and speed.
    function automatic logic [31:0] euro_axis(int ax, logic [31:0] med, logic [63:0] dt,
                                              longint a_spd);
        longint      m;
        longint      diff;
        longint      raw;
        logic [63:0] mag;
        logic [63:0] fc;
        begin
            m = longint'($signed(med));
            if (!primed[ax])
            begin
                primed[ax] = 1'b1;
                smooth[ax] = m;
                speed[ax] = 0;
                return med;
            end
            diff = m - smooth[ax];
            mag = (diff < 0) ? -diff : diff;
            mag = mag * SPEED_SCALE / dt;
            if (diff < 0)
                raw = (mag >= (64'd1 << 39)) ? -(longint'(1) << 39) : -longint'(mag);
            else
                raw = (mag > (64'd1 << 39) - 1) ? (longint'(1) << 39) - 1 : longint'(mag);
            speed[ax] = low_pass(raw, speed[ax], a_spd);
            mag = (speed[ax] < 0) ? -speed[ax] : speed[ax];
            fc = 64'(min_cut_mhz) + ((((64'(gain_q16) * mag) >> 16) * MHZ_SCALE) >> 16);
            smooth[ax] = low_pass(m, smooth[ax], smoothing_factor(dt, fc));
            return smooth[ax][31:0];
        end
    endfunction

    // Filtered word for one accepted input word.
    function automatic logic [63:0] filter_word(logic [87:0] w);
        logic [63:0] nom;
        logic [63:0] dt;
        longint      a_spd;
        logic [31:0] ox;
        logic [31:0] oy;
        begin
            nom = (nominal_us == 0) ? 64'd1 : 64'(nominal_us);
            dt = 64'(w[87:64]) * 10;
            if (dt == 0)
                dt = nom * 10;
            if (dt < nom)
                dt = nom;
            if (dt > nom * 500)
                dt = nom * 500;
            hist_x[slot] = w[31:0];
            hist_y[slot] = w[63:32];
            slot = (slot + 1) % 3;
            if (fill < 3)
                fill++;
            a_spd = smoothing_factor(dt, 64'(speed_cut_mhz));
            ox = euro_axis(0, window_median(hist_x, fill), dt, a_spd);
            oy = euro_axis(1, window_median(hist_y, fill), dt, a_spd);
            return {oy, ox};
        end
    endfunction

    // Predict on every accepted input word, check every accepted output word.
    always @(posedge clk)
    begin
        logic [63:0] want;
        logic [64:0] typed;
        if (s_tvalid && s_tready)
        begin
            want = filter_word(s_tdata);
            typed = typed_words.pop_front();
            filtered_words.push_back(typed[64] ? typed[63:0] : want);
        end
        if (m_tvalid && m_tready)
        begin
            if (filtered_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected output word %h", m_tdata);
            end
            else
            begin
                want = filtered_words.pop_front();
                if (want[31:0] !== m_tdata[31:0] || want[63:32] !== m_tdata[63:32])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("x_filt/y_filt expected %h/%h, got %h/%h",
                                 want[31:0], want[63:32], m_tdata[31:0], m_tdata[63:32]);
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_request && hold_left == 0)
        begin
            hold_request <= 1'b0;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= (hold_left == 1);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end
        else if (!quiet && $urandom_range(0, 19) == 0)
        begin
            stall_left <= $urandom_range(1, 15);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no word moves.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Register write followed by a read back.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] mask;
        begin
            mask = (idx == REG_GAIN) ? 32'hFF_FFFF : 32'hF_FFFF;
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            case (idx)
                REG_NOMINAL:   nominal_us = value[19:0];
                REG_MIN_CUT:   min_cut_mhz = value[19:0];
                REG_GAIN:      gain_q16 = value[23:0];
                REG_SPEED_CUT: speed_cut_mhz = value[19:0];
            endcase
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if ((prdata & mask) !== (value & mask))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Register %0d read %h, expected %h", idx, prdata, value & mask);
            end
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Offers one word and waits until it is taken, then maybe idles.
    task automatic send_word(logic [31:0] x, logic [31:0] y, logic [23:0] iv,
                             bit fixed, logic [63:0] want);
        int gap;
        begin
            typed_words.push_back({fixed, want});
            s_tvalid <= 1'b1;
            s_tdata <= {iv, y, x};
            do
                @(posedge clk);
            while (!s_tready);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 15);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Waits until every expected word has come back.
    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            while (filtered_words.size() != 0 || typed_words.size() != 0)
                @(posedge clk);
            repeat (40) @(posedge clk);
        end
    endtask

    // Stimulus.
    initial
    begin
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] x;
        logic [31:0] y;
        logic [23:0] iv;
        int          nom;
        int          pick;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        idle_cycles = 0;
        hold_request = 1'b0;
        quiet = 1'b0;
        hold_left = 0;
        stall_left = 0;
        nominal_us = 20'd1000;
        min_cut_mhz = 20'd1000;
        gain_q16 = 24'd0;
        speed_cut_mhz = 20'd1000;
        slot = 0;
        fill = 0;
        for (int i = 0; i < 2; i++)
        begin
            primed[i] = 1'b0;
            smooth[i] = 0;
            speed[i] = 0;
        end

        // The priming word passes through; the rest exercise clamps and extremes.
        directed[0]  = '{32'h7FFF_FFFF, 32'h8000_0000, 24'd0, 1'b1,
                         {32'h8000_0000, 32'h7FFF_FFFF}};
        directed[1]  = '{32'h8000_0000, 32'h7FFF_FFFF, 24'd1, 1'b0, '0};
        directed[2]  = '{32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF, 1'b0, '0};
        directed[3]  = '{32'h0000_0001, 32'hFFFF_FFFF, 24'd100, 1'b0, '0};
        directed[4]  = '{32'h0001_0000, 32'hFFFF_0000, 24'd0, 1'b0, '0};
        directed[5]  = '{32'h1234_5678, 32'h8765_4321, 24'd200000, 1'b0, '0};
        directed[6]  = '{32'h1234_5678, 32'h8765_4321, 24'd1000, 1'b0, '0};
        directed[7]  = '{32'h1234_5678, 32'h8765_4321, 24'd1000, 1'b0, '0};
        directed[8]  = '{32'h7FFF_FFFF, 32'h8000_0000, 24'd500000, 1'b0, '0};
        directed[9]  = '{32'h8000_0000, 32'h7FFF_FFFF, 24'd99, 1'b0, '0};
        directed[10] = '{32'hAAAA_AAAA, 32'h5555_5555, 24'hAAAAAA, 1'b0, '0};
        directed[11] = '{32'h5555_5555, 32'hAAAA_AAAA, 24'h555555, 1'b0, '0};

        phases[0] = '{32'd1000, 32'd1000, 32'd0, 32'd1000};
        phases[1] = '{32'd1, 32'd0, 32'd0, 32'd0};
        phases[2] = '{32'd1000000, 32'd1000000, 32'd16777215, 32'd1000000};
        phases[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        phases[4] = '{32'd0, 32'd5000, 32'd65536, 32'd2000};
        phases[5] = '{32'd4000, 32'd1500, 32'd300, 32'd1000};
        phases[6] = '{32'd8000, 32'd500, 32'd4096, 32'd20000};
        phases[7] = '{$urandom_range(1, 20000), $urandom_range(0, 100000),
                      $urandom_range(0, 1 << 20), $urandom_range(1, 100000)};
        phases[8] = '{32'd1000, 32'd1000, 32'd1000, 32'd1000};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(directed[i].x, directed[i].y, directed[i].iv,
                      directed[i].fixed, directed[i].want);
        drain();

        // Random phases: mostly a smooth random walk, some jumps and odd intervals.
        px = $urandom;
        py = $urandom;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_reg(REG_NOMINAL, phases[ph].nominal);
            write_reg(REG_MIN_CUT, phases[ph].min_cut);
            write_reg(REG_GAIN, phases[ph].gain);
            write_reg(REG_SPEED_CUT, phases[ph].speed_cut);
            quiet = (ph == N_PHASES - 1);
            nom = (nominal_us == 0) ? 1 : nominal_us;
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (ph == 2 && k == 20)
                    hold_request = 1'b1;
                pick = $urandom_range(0, 99);
                px = px + 32'($signed(10'($urandom))) * 32'd64;
                py = py + 32'($signed(10'($urandom))) * 32'd64;
                x = px;
                y = py;
                if (pick < 8)
                begin
                    x = $urandom;
                    y = $urandom;
                end
                else if (pick < 12)
                begin
                    x = pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
                    y = pick[1] ? 32'h7FFF_FFFF : 32'h8000_0000;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    iv = 24'($urandom_range(nom / 2 + 1, nom * 2 < 16777215 ? nom * 2 : 16777215));
                else if (pick < 80)
                    iv = 24'd0;
                else if (pick < 90)
                    iv = 24'($urandom);
                else
                    iv = pick[0] ? 24'hFF_FFFF : 24'($urandom_range(1, 3));
                send_word(x, y, iv, 1'b0, '0);
            end
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
sv/moexy_pkg.sv
sv/moexy_alu.sv
sv/moexy_median.sv
sv/median_one_euro_xy_filter.sv
sv/moexy_checker.sv
bench/testbench.sv
